### rtl/bclk_pkg.sv
`timescale 1ns / 1ps
// Types and constants for the button click mode controller.
// No dependencies; imported by every module of the block.
package bclk_pkg;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_CLICK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT    = 2'd1;

	localparam logic [7:0]  LONG_CLICK_RST = 8'd10;
	localparam logic [15:0] LOCKOUT_RST    = 16'd1000;

	localparam logic [1:0] SCALE_SINGLE  = 2'd0;
	localparam logic [1:0] SCALE_RISING  = 2'd1;
	localparam logic [1:0] SCALE_FALLING = 2'd2;

	localparam logic [9:0]  DUR_30MS   = 10'd30;
	localparam logic [9:0]  DUR_100MS  = 10'd100;
	localparam logic [9:0]  DUR_500MS  = 10'd500;
	localparam logic [15:0] TONE_DEF   = 16'd65;
	localparam logic [15:0] TONE_300   = 16'd300;
	localparam logic [15:0] TONE_500   = 16'd500;

	typedef enum logic [1:0] {
		MODE_STOP = 2'd0,
		MODE_PLAY = 2'd1,
		MODE_FF   = 2'd2
	} bclk_mode_t;

	typedef struct packed {
		logic        button_level;
		logic [15:0] timer_count;
	} bclk_item_t;

	typedef struct packed {
		logic        tick_accepted;
		logic        motor_valid;
		logic [1:0]  motor_command;
		logic        beep_valid;
		logic [9:0]  beep_duration_ms;
		logic [15:0] beep_tone;
		logic [1:0]  beep_scale;
		logic        direction_forward;
	} bclk_result_t;

	typedef struct packed {
		logic [7:0]  long_click_ticks;
		logic [15:0] lockout_counts;
	} bclk_cfg_t;

	typedef struct packed {
		logic [7:0] press_count;
		bclk_mode_t mode;
		logic       direction;
	} bclk_ctrl_t;

endpackage

### rtl/bclk_step.sv
`timescale 1ns / 1ps
// Per-tick classifier: lockout with timer wrap, press counting, click decode.
// Depends on bclk_pkg.
module bclk_step #(
	parameter int TIMER_BITS = 16
) (
	input  bclk_pkg::bclk_item_t   item,
	input  bclk_pkg::bclk_cfg_t    cfg,
	input  bclk_pkg::bclk_ctrl_t   ctrl_cur,
	input  logic signed [((TIMER_BITS > 16) ? TIMER_BITS : 16)+1:0] last_cur,
	output bclk_pkg::bclk_ctrl_t   ctrl_nxt,
	output logic signed [((TIMER_BITS > 16) ? TIMER_BITS : 16)+1:0] last_nxt,
	output bclk_pkg::bclk_result_t result
);
	import bclk_pkg::*;

	localparam int LW = ((TIMER_BITS > 16) ? TIMER_BITS : 16) + 2;
	localparam logic [LW-1:0] TMASK = {LW{1'b1}} >> (LW - TIMER_BITS);
	localparam logic [LW-1:0] SPAN  = {{(LW-1){1'b0}}, 1'b1} << TIMER_BITS;

	logic signed [LW-1:0] t;
	logic signed [LW-1:0] adj;
	logic signed [LW-1:0] thr;
	logic                 blocked;
	logic [7:0]           limit;
	logic [7:0]           pc_inc;

	always_comb begin
		t       = signed'({{(LW-16){1'b0}}, item.timer_count} & TMASK);
		adj     = (t < last_cur) ? (last_cur - signed'(SPAN)) : last_cur;
		thr     = adj + signed'({{(LW-16){1'b0}}, cfg.lockout_counts});
		blocked = (t < thr);
		limit   = (cfg.long_click_ticks == 8'hFF) ? 8'hFF : (cfg.long_click_ticks + 8'd1);
		pc_inc  = ctrl_cur.press_count + 8'd1;
	end

	always_comb begin
		ctrl_nxt = ctrl_cur;
		last_nxt = blocked ? adj : t;
		result   = '0;
		if (!blocked) begin
			result.tick_accepted = 1'b1;
			if (item.button_level) begin
				if (ctrl_cur.press_count < limit) begin
					ctrl_nxt.press_count = pc_inc;
					if (pc_inc == cfg.long_click_ticks) begin
						ctrl_nxt.direction      = ~ctrl_cur.direction;
						result.beep_valid       = 1'b1;
						result.beep_duration_ms = DUR_100MS;
						result.beep_tone        = TONE_500;
						result.beep_scale       = ctrl_cur.direction ? SCALE_FALLING
							: SCALE_RISING;
					end
				end
			end else begin
				if (ctrl_cur.press_count != 8'd0
						&& ctrl_cur.press_count < cfg.long_click_ticks) begin
					result.beep_valid  = 1'b1;
					result.beep_scale  = SCALE_SINGLE;
					result.motor_valid = 1'b1;
					case (ctrl_cur.mode)
						MODE_PLAY: begin
							ctrl_nxt.mode           = MODE_FF;
							result.beep_duration_ms = DUR_100MS;
							result.beep_tone        = TONE_300;
						end
						MODE_FF: begin
							ctrl_nxt.mode           = MODE_STOP;
							result.beep_duration_ms = DUR_500MS;
							result.beep_tone        = TONE_500;
						end
						default: begin
							ctrl_nxt.mode           = MODE_PLAY;
							result.beep_duration_ms = DUR_30MS;
							result.beep_tone        = TONE_DEF;
						end
					endcase
					result.motor_command = ctrl_nxt.mode;
				end
				ctrl_nxt.press_count = 8'd0;
			end
		end
		result.direction_forward = ctrl_nxt.direction;
	end

endmodule

### rtl/button_click_mode_controller_core.sv
`timescale 1ns / 1ps
// Button click mode controller: one result per poll tick.
// Path: the item goes into the input reg, then its step result into the result reg; a held
// result stalls the input reg, so the item waits there until the result is taken.
// Throughput: 1 item per cycle; the input stage stalls only while a result is held.
// Reset: config to 10 ticks / 1000 counts, mode stop, direction forward, pipe empty.
// Depends on bclk_pkg and bclk_step.
module button_click_mode_controller_core #(
	parameter int TIMER_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_stall,
	input  bclk_pkg::bclk_item_t             item,
	output logic                             result_valid,
	input  logic                             result_stall,
	output bclk_pkg::bclk_result_t           result,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bclk_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [15:0]                      cfg_data
);
	import bclk_pkg::*;

	localparam int LW = ((TIMER_BITS > 16) ? TIMER_BITS : 16) + 2;

	bclk_item_t           item_s1;
	logic                 vld_s1;
	bclk_result_t         result_s2;
	logic                 vld_s2;
	bclk_cfg_t            cfg_q;
	bclk_ctrl_t           ctrl_q;
	bclk_ctrl_t           ctrl_d;
	logic signed [LW-1:0] last_q;
	logic signed [LW-1:0] last_d;
	bclk_result_t         step_res;
	logic                 adv;

	assign cfg_ready    = 1'b1;
	assign adv          = vld_s1 && (!vld_s2 || !result_stall);
	assign item_stall   = vld_s1 && !adv;
	assign result_valid = vld_s2;
	assign result       = result_s2;

	bclk_step #(
		.TIMER_BITS(TIMER_BITS)
	) u_step (
		.item     (item_s1),
		.cfg      (cfg_q),
		.ctrl_cur (ctrl_q),
		.last_cur (last_q),
		.ctrl_nxt (ctrl_d),
		.last_nxt (last_d),
		.result   (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_click_ticks <= LONG_CLICK_RST;
			cfg_q.lockout_counts   <= LOCKOUT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_LONG_CLICK: cfg_q.long_click_ticks <= cfg_data[7:0];
				CFG_LOCKOUT:    cfg_q.lockout_counts   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= 1'b1;
		end else if (!result_stall) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_s2 <= step_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q.press_count <= 8'd0;
			ctrl_q.mode        <= MODE_STOP;
			ctrl_q.direction   <= 1'b1;
			last_q             <= '0;
		end else if (adv) begin
			ctrl_q <= ctrl_d;
			last_q <= last_d;
		end
	end

endmodule

### rtl/bclk_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the button click mode controller, bound to the top level.
// Depends on bclk_pkg and button_click_mode_controller_core.
module bclk_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             result_valid,
	input logic                             result_stall,
	input bclk_pkg::bclk_result_t           result
);
	import bclk_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	a_blocked_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.tick_accepted |-> !result.motor_valid && !result.beep_valid)
		else $error("blocked tick issued a command");

	a_motor_beep: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.motor_valid
			|-> result.beep_valid && result.beep_scale == SCALE_SINGLE)
		else $error("short click without single beep");

	a_scale_dir: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.beep_valid && result.beep_scale != SCALE_SINGLE
			|-> (result.beep_scale == SCALE_RISING) == result.direction_forward)
		else $error("scale disagrees with direction");

endmodule

bind button_click_mode_controller_core bclk_checker u_bclk_checker (.*);

### tb/tb_button_click_mode_controller_core.sv
`timescale 1ns / 1ps
// Testbench for button_click_mode_controller_core: a table of directed ticks, then
// random press/release sequences under several register settings and stall patterns.
// Depends on bclk_pkg and the core RTL; results are checked against an in-bench predictor.
module tb_button_click_mode_controller_core;
	import bclk_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
	localparam int LONG_HOLD_CYCLES = 300;

	typedef struct {
		bclk_item_t   tick;
		bit           pinned;
		bclk_result_t want;
	} tick_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	bclk_item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	bclk_result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_LONG_CLICK;
	logic [15:0] cfg_data = '0;

	// predictor state
	logic [7:0]  long_ticks_reg = LONG_CLICK_RST;
	logic [15:0] lockout_reg = LOCKOUT_RST;
	int          last_accept = 0;
	logic [7:0]  held_ticks = '0;
	bclk_mode_t  play_mode = MODE_STOP;
	logic        dir_fwd = 1'b1;

	bclk_result_t tick_results_due[$];
	tick_row_t    directed_rows[$];
	logic [15:0]  timer_now = '0;
	int ticks_sent = 0;
	int ticks_accepted = 0;
	int short_clicks = 0;
	int long_clicks = 0;
	int results_checked = 0;
	int error_count = 0;
	int send_idle_pct = 25;
	int recv_idle_pct = 60;
	int stall_hold = 0;
	logic hold_req = 1'b0;

	button_click_mode_controller_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

	task automatic flag_error(input string msg);
		error_count++;
		$display("ERROR @%0t: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			flag_error($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	function automatic bclk_result_t classify_tick(input bclk_item_t tk);
		bclk_result_t r;
		int t;
		int cap;
		r = '0;
		t = int'(tk.timer_count);
		if (t < last_accept)
			last_accept -= 65536;
		if (t < last_accept + int'(lockout_reg)) begin
			r.direction_forward = dir_fwd;
			return r;
		end
		last_accept = t;
		r.tick_accepted = 1'b1;
		ticks_accepted++;
		cap = int'(long_ticks_reg) + 1;
		if (cap > 255)
			cap = 255;
		if (tk.button_level) begin
			if (int'(held_ticks) < cap) begin
				held_ticks++;
				if (held_ticks == long_ticks_reg) begin
					dir_fwd = ~dir_fwd;
					r.beep_valid = 1'b1;
					r.beep_duration_ms = DUR_100MS;
					r.beep_tone = TONE_500;
					r.beep_scale = dir_fwd ? SCALE_RISING : SCALE_FALLING;
					long_clicks++;
				end
			end
		end else begin
			if (held_ticks != 0 && held_ticks < long_ticks_reg) begin
				case (play_mode)
					MODE_PLAY: begin
						r.beep_duration_ms = DUR_100MS;
						r.beep_tone = TONE_300;
						play_mode = MODE_FF;
					end
					MODE_FF: begin
						r.beep_duration_ms = DUR_500MS;
						r.beep_tone = TONE_500;
						play_mode = MODE_STOP;
					end
					default: begin
						r.beep_duration_ms = DUR_30MS;
						r.beep_tone = TONE_DEF;
						play_mode = MODE_PLAY;
					end
				endcase
				r.beep_valid = 1'b1;
				r.beep_scale = SCALE_SINGLE;
				r.motor_valid = 1'b1;
				r.motor_command = play_mode;
				short_clicks++;
			end
			held_ticks = '0;
		end
		r.direction_forward = dir_fwd;
		return r;
	endfunction

	// mostly steps past the lockout, sometimes lands inside it
	function automatic logic [15:0] advance_timer();
		int step;
		if (lockout_reg != 0 && $urandom_range(0, 99) < 15)
			step = $urandom_range(0, int'(lockout_reg) - 1);
		else
			step = int'(lockout_reg) + $urandom_range(0, 300);
		timer_now = timer_now + step[15:0];
		return timer_now;
	endfunction

	task automatic add_row(input logic btn, input logic [15:0] tmr, input bit pinned,
			input bclk_result_t want);
		tick_row_t row;
		row.tick.button_level = btn;
		row.tick.timer_count = tmr;
		row.pinned = pinned;
		row.want = want;
		directed_rows.push_back(row);
	endtask

	// called at a falling edge; returns at the falling edge after the transaction
	task automatic push_tick(input bclk_item_t tk, input bit pinned, input bclk_result_t given);
		bclk_result_t want;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= tk;
		do @(posedge clk); while (item_stall);
		want = classify_tick(tk);
		tick_results_due.push_back(pinned ? given : want);
		ticks_sent++;
		@(negedge clk);
	endtask

	task automatic run_press(input int hold, input bit with_release);
		bclk_item_t tk;
		int k;
		for (k = 0; k < hold; k++) begin
			tk.button_level = 1'b1;
			tk.timer_count = advance_timer();
			push_tick(tk, 1'b0, '0);
		end
		if (with_release) begin
			tk.button_level = 1'b0;
			tk.timer_count = advance_timer();
			push_tick(tk, 1'b0, '0);
		end
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		while (tick_results_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_LONG_CLICK: long_ticks_reg = data[7:0];
			CFG_LOCKOUT:    lockout_reg = data;
			default: ;
		endcase
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		if (hold_req) begin
			hold_req <= 1'b0;
			stall_hold = LONG_HOLD_CYCLES;
		end
		if (stall_hold > 0) begin
			stall_hold--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin : result_check
		bclk_result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (tick_results_due.size() == 0) begin
				flag_error("result transaction with nothing expected");
			end else begin
				want = tick_results_due.pop_front();
				check_field("tick_accepted", result.tick_accepted, want.tick_accepted);
				check_field("motor_valid", result.motor_valid, want.motor_valid);
				check_field("motor_command", result.motor_command, want.motor_command);
				check_field("beep_valid", result.beep_valid, want.beep_valid);
				check_field("beep_duration_ms", result.beep_duration_ms,
					want.beep_duration_ms);
				check_field("beep_tone", result.beep_tone, want.beep_tone);
				check_field("beep_scale", result.beep_scale, want.beep_scale);
				check_field("direction_forward", result.direction_forward,
					want.direction_forward);
				results_checked++;
			end
		end
	end

	initial begin
		int s;
		int hold;
		int pick;
		int chunk_end;
		int mid_mark;
		bit paused;
		bclk_item_t tk;
		int lc_plan[6];
		int lock_plan[6];
		int size_plan[6];

		lc_plan = '{10, 1, 0, 254, 2, 255};
		lock_plan = '{1000, 0, 500, 7, 65535, 3};
		size_plan = '{260, 240, 200, 320, 120, 300};

		// reset config: 10 ticks, 1000 counts
		add_row(1'b0, 16'd0, 1'b1,
			'{1'b0, 1'b0, MODE_STOP, 1'b0, 10'd0, 16'd0, SCALE_SINGLE, 1'b1});
		add_row(1'b0, 16'd999, 1'b1,
			'{1'b0, 1'b0, MODE_STOP, 1'b0, 10'd0, 16'd0, SCALE_SINGLE, 1'b1});
		add_row(1'b0, 16'd1000, 1'b1,
			'{1'b1, 1'b0, MODE_STOP, 1'b0, 10'd0, 16'd0, SCALE_SINGLE, 1'b1});
		add_row(1'b1, 16'd2000, 1'b0, '0);
		add_row(1'b0, 16'd3000, 1'b1,
			'{1'b1, 1'b1, MODE_PLAY, 1'b1, DUR_30MS, TONE_DEF, SCALE_SINGLE, 1'b1});
		add_row(1'b1, 16'd4000, 1'b0, '0);
		add_row(1'b0, 16'd5000, 1'b1,
			'{1'b1, 1'b1, MODE_FF, 1'b1, DUR_100MS, TONE_300, SCALE_SINGLE, 1'b1});
		add_row(1'b1, 16'd6000, 1'b0, '0);
		add_row(1'b0, 16'd7000, 1'b1,
			'{1'b1, 1'b1, MODE_STOP, 1'b1, DUR_500MS, TONE_500, SCALE_SINGLE, 1'b1});
		for (s = 0; s < 9; s++)
			add_row(1'b1, 16'(8000 + 1000 * s), 1'b0, '0);
		add_row(1'b1, 16'd17000, 1'b1,
			'{1'b1, 1'b0, MODE_STOP, 1'b1, DUR_100MS, TONE_500, SCALE_FALLING, 1'b0});
		// held past the long click: counter saturates, release is silent
		add_row(1'b1, 16'd18000, 1'b0, '0);
		add_row(1'b1, 16'd19000, 1'b0, '0);
		add_row(1'b0, 16'd20000, 1'b0, '0);
		// timer wrap: blocked just after wrap, accepted once the lockout has run out
		add_row(1'b1, 16'd65535, 1'b0, '0);
		add_row(1'b0, 16'd400, 1'b1,
			'{1'b0, 1'b0, MODE_STOP, 1'b0, 10'd0, 16'd0, SCALE_SINGLE, 1'b0});
		add_row(1'b0, 16'd999, 1'b0, '0);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			push_tick(directed_rows[i].tick, directed_rows[i].pinned, directed_rows[i].want);
		timer_now = 16'd999;

		for (s = 0; s < 6; s++) begin
			wait_drained();
			send_idle_pct <= (s < 2) ? 25 : (s < 4) ? 60 : 0;
			recv_idle_pct <= (s < 2) ? 60 : (s < 4) ? 25 : 0;
			if (s == 5) begin
				write_reg(CFG_SPARE_A, 16'($urandom_range(0, 65535)));
				write_reg(CFG_SPARE_B, 16'($urandom_range(0, 65535)));
			end
			write_reg(CFG_LONG_CLICK, 16'(lc_plan[s]));
			write_reg(CFG_LOCKOUT, 16'(lock_plan[s]));
			cfg_valid <= 1'b0;
			if (s % 2 == 0)
				hold_req <= 1'b1;
			chunk_end = ticks_sent + size_plan[s];
			mid_mark = ticks_sent + size_plan[s] / 2;
			paused = 1'b0;
			while (ticks_sent < chunk_end) begin
				if (!paused && ticks_sent >= mid_mark) begin
					wait_drained();
					paused = 1'b1;
				end
				pick = $urandom_range(0, 99);
				if (pick < 15) begin
					tk.button_level = 1'($urandom_range(0, 1));
					tk.timer_count = 16'($urandom_range(0, 65535));
					timer_now = tk.timer_count;
					push_tick(tk, 1'b0, '0);
				end else begin
					case ($urandom_range(0, 9))
						0, 1, 2, 3, 4: hold = $urandom_range(1, 4);
						5: hold = 0;
						6: hold = (lc_plan[s] > 1) ? lc_plan[s] - 1 : 1;
						7: hold = lc_plan[s];
						8: hold = lc_plan[s] + $urandom_range(1, 3);
						default: hold = $urandom_range(0, lc_plan[s] + 2);
					endcase
					// keep the chunk near its planned size
					if (hold > chunk_end - ticks_sent)
						hold = chunk_end - ticks_sent;
					// a few presses are cut short by noise instead of a release
					run_press(hold, pick >= 23);
				end
			end
		end

		wait_drained();
		repeat (10) @(posedge clk);
		$display("Sent %0d ticks over 6 register settings and 3 stall patterns: %0d accepted,",
			ticks_sent, ticks_accepted);
		$display("%0d short clicks, %0d long clicks, %0d results checked",
			short_clicks, long_clicks, results_checked);
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
